@@ src/dcp_pkg.sv @@
// Shared types and constants for the distance constraint projection block.
package dcp_pkg;

  localparam int SQRT_STEPS = 33;  // root bits of a 66 bit radicand
  localparam int DIV_STEPS  = 31;  // quotient bits of the unit direction
  localparam int RAD_W      = 66;
  localparam int LEN_W      = 33;
  localparam int REM_W      = 35;
  localparam int DIVR_W     = 34;
  localparam int U_W        = 31;
  localparam int M_W        = 32;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [16:0]        first_weight;
    logic [16:0]        second_weight;
    logic [30:0]        rest_length;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [31:0] length_error;
    logic               degenerate;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [16:0]        w1;
    logic [16:0]        w2;
    logic [30:0]        rest;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic               negx;
    logic               negy;
    logic               deg;
  } work_t;

endpackage

@@ src/dcp_front.sv @@
// Front end: take a request, form the difference vector and classify it.
module dcp_front import dcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  work_valid,
  input  logic  work_ready,
  output work_t work
);

  logic               valid;
  work_t              item;
  work_t              item_next;
  logic signed [32:0] dx;
  logic signed [32:0] dy;

  assign in_ready   = !valid || work_ready;
  assign work_valid = valid;
  assign work       = item;

  always_comb begin
    dx = {in_data.second_x[31], in_data.second_x} - {in_data.first_x[31], in_data.first_x};
    dy = {in_data.second_y[31], in_data.second_y} - {in_data.first_y[31], in_data.first_y};
    item_next.fx   = in_data.first_x;
    item_next.fy   = in_data.first_y;
    item_next.sx   = in_data.second_x;
    item_next.sy   = in_data.second_y;
    item_next.w1   = in_data.first_weight;
    item_next.w2   = in_data.second_weight;
    item_next.rest = in_data.rest_length;
    item_next.ax   = dx[32] ? 33'(-dx) : 33'(dx);
    item_next.ay   = dy[32] ? 33'(-dy) : 33'(dy);
    item_next.negx = dx[32];
    item_next.negy = dy[32];
    item_next.deg  = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

@@ src/dcp_queue.sv @@
// Short request queue between the front and back ends.
module dcp_queue import dcp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_work,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_work
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  work_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_work   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_work;
    end
  end

endmodule

@@ src/dcp_back.sv @@
// Back end: length by pipelined square root, direction by pipelined division, corrections.
module dcp_back import dcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  work_valid,
  output logic  work_ready,
  input  work_t work,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] apply(input logic signed [31:0] p,
                                               input logic [31:0] c,
                                               input logic neg);
    logic signed [34:0] cs;
    cs = neg ? -$signed({3'b000, c}) : $signed({3'b000, c});
    return sat32($signed({{3{p[31]}}, p}) + cs);
  endfunction

  logic adv;
  assign adv        = !out_valid || out_ready;
  assign work_ready = adv;

  // squares
  logic        a_valid;
  work_t       a_work;
  logic [64:0] a_sqx;
  logic [64:0] a_sqy;
  // square root steps; stage 0 holds the radicand
  logic             s_valid [0:SQRT_STEPS];
  work_t            s_work  [0:SQRT_STEPS];
  logic [RAD_W-1:0] s_rad   [0:SQRT_STEPS];
  logic [REM_W-1:0] s_rem   [0:SQRT_STEPS];
  logic [LEN_W-1:0] s_root  [0:SQRT_STEPS];
  logic [REM_W-1:0] s_rem_next  [0:SQRT_STEPS-1];
  logic [LEN_W-1:0] s_root_next [0:SQRT_STEPS-1];
  // length error
  logic               e_valid;
  work_t              e_work;
  logic [LEN_W-1:0]   e_len;
  logic signed [31:0] e_err;
  logic signed [34:0] e_diff;
  logic [31:0]        e_mag;
  // division steps
  logic               d_valid [0:DIV_STEPS];
  work_t              d_work  [0:DIV_STEPS];
  logic [LEN_W-1:0]   d_len   [0:DIV_STEPS];
  logic signed [31:0] d_err   [0:DIV_STEPS];
  logic [M_W-1:0]     d_m1    [0:DIV_STEPS];
  logic [M_W-1:0]     d_m2    [0:DIV_STEPS];
  logic [DIVR_W-1:0]  d_rx    [0:DIV_STEPS];
  logic [DIVR_W-1:0]  d_ry    [0:DIV_STEPS];
  logic [U_W-1:0]     d_qx    [0:DIV_STEPS];
  logic [U_W-1:0]     d_qy    [0:DIV_STEPS];
  logic [DIVR_W-1:0]  d_rx_next [0:DIV_STEPS-1];
  logic [DIVR_W-1:0]  d_ry_next [0:DIV_STEPS-1];
  logic               d_bx [0:DIV_STEPS-1];
  logic               d_by [0:DIV_STEPS-1];
  logic [48:0]        m1_full;
  logic [48:0]        m2_full;
  // products
  logic               p_valid;
  work_t              p_work;
  logic signed [31:0] p_err;
  logic [62:0]        p_x1;
  logic [62:0]        p_y1;
  logic [62:0]        p_x2;
  logic [62:0]        p_y2;
  // output
  out_t               o_data;
  logic               o_valid;
  out_t               o_next;
  logic               en;

  // one root bit per step: bring down two radicand bits, try 4r+1
  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      logic [REM_W-1:0] t_rem;
      logic [REM_W-1:0] t_try;
      logic             ge;
      t_rem = {s_rem[k][REM_W-3:0], s_rad[k][RAD_W-1 -: 2]};
      t_try = {1'b0, s_root[k][LEN_W-2:0], 2'b01};
      ge    = t_rem >= t_try;
      s_rem_next[k]  = ge ? t_rem - t_try : t_rem;
      s_root_next[k] = {s_root[k][LEN_W-2:0], ge};
    end
  end

  always_comb begin
    e_diff = $signed({2'b00, s_root[SQRT_STEPS]}) - $signed({4'b0000, s_work[SQRT_STEPS].rest});
    e_mag  = e_err[31] ? 32'(-e_err) : 32'(e_err);
    m1_full = 49'(e_mag) * 49'(e_work.w1);
    m2_full = 49'(e_mag) * 49'(e_work.w2);
  end

  // one quotient bit per step; only the first step brings in a nonzero bit
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      logic [DIVR_W-1:0] tx;
      logic [DIVR_W-1:0] ty;
      tx = {d_rx[k][DIVR_W-2:0], (k == 0) ? d_work[k].ax[0] : 1'b0};
      ty = {d_ry[k][DIVR_W-2:0], (k == 0) ? d_work[k].ay[0] : 1'b0};
      d_bx[k] = tx >= {1'b0, d_len[k]};
      d_by[k] = ty >= {1'b0, d_len[k]};
      d_rx_next[k] = d_bx[k] ? tx - {1'b0, d_len[k]} : tx;
      d_ry_next[k] = d_by[k] ? ty - {1'b0, d_len[k]} : ty;
    end
  end

  always_comb begin
    o_next.length_error = p_err;
    o_next.degenerate   = p_work.deg;
    if (p_work.deg) begin
      o_next.new_first_x  = p_work.fx;
      o_next.new_first_y  = p_work.fy;
      o_next.new_second_x = p_work.sx;
      o_next.new_second_y = p_work.sy;
    end else begin
      o_next.new_first_x  = apply(p_work.fx, p_x1[61:30], p_work.negx != p_err[31]);
      o_next.new_first_y  = apply(p_work.fy, p_y1[61:30], p_work.negy != p_err[31]);
      o_next.new_second_x = apply(p_work.sx, p_x2[61:30], p_work.negx == p_err[31]);
      o_next.new_second_y = apply(p_work.sy, p_y2[61:30], p_work.negy == p_err[31]);
    end
  end

  assign en = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      e_valid <= 1'b0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        s_valid[k] <= 1'b0;
      end
      for (int k = 0; k <= DIV_STEPS; k++) begin
        d_valid[k] <= 1'b0;
      end
    end else if (en) begin
      a_valid    <= work_valid;
      s_valid[0] <= a_valid;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        s_valid[k] <= s_valid[k-1];
      end
      e_valid    <= s_valid[SQRT_STEPS];
      d_valid[0] <= e_valid;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        d_valid[k] <= d_valid[k-1];
      end
      p_valid <= d_valid[DIV_STEPS];
      o_valid <= p_valid;
    end
    if (en) begin
      a_work    <= work;
      a_sqx     <= 65'(work.ax) * 65'(work.ax);
      a_sqy     <= 65'(work.ay) * 65'(work.ay);
      s_work[0] <= a_work;
      s_rad[0]  <= {1'b0, a_sqx} + {1'b0, a_sqy};
      s_rem[0]  <= '0;
      s_root[0] <= '0;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        s_work[k] <= s_work[k-1];
        s_rad[k]  <= s_rad[k-1] << 2;
        s_rem[k]  <= s_rem_next[k-1];
        s_root[k] <= s_root_next[k-1];
      end
      e_work <= s_work[SQRT_STEPS];
      e_len  <= s_root[SQRT_STEPS];
      e_err  <= sat32(e_diff);
      d_work[0] <= e_work;
      d_len[0]  <= e_len;
      d_err[0]  <= e_err;
      d_m1[0]   <= m1_full[47:16];
      d_m2[0]   <= m2_full[47:16];
      d_rx[0]   <= {2'b00, e_work.ax[32:1]};
      d_ry[0]   <= {2'b00, e_work.ay[32:1]};
      d_qx[0]   <= '0;
      d_qy[0]   <= '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        d_work[k] <= d_work[k-1];
        d_len[k]  <= d_len[k-1];
        d_err[k]  <= d_err[k-1];
        d_m1[k]   <= d_m1[k-1];
        d_m2[k]   <= d_m2[k-1];
        d_rx[k]   <= d_rx_next[k-1];
        d_ry[k]   <= d_ry_next[k-1];
        d_qx[k]   <= {d_qx[k-1][U_W-2:0], d_bx[k-1]};
        d_qy[k]   <= {d_qy[k-1][U_W-2:0], d_by[k-1]};
      end
      p_work <= d_work[DIV_STEPS];
      p_err  <= d_err[DIV_STEPS];
      p_x1   <= 63'(d_qx[DIV_STEPS]) * 63'(d_m1[DIV_STEPS]);
      p_y1   <= 63'(d_qy[DIV_STEPS]) * 63'(d_m1[DIV_STEPS]);
      p_x2   <= 63'(d_qx[DIV_STEPS]) * 63'(d_m2[DIV_STEPS]);
      p_y2   <= 63'(d_qy[DIV_STEPS]) * 63'(d_m2[DIV_STEPS]);
      o_data <= o_next;
    end
  end

  assign out_valid = o_valid;
  assign out_data  = o_data;

endmodule

@@ src/distance_constraint_projection.sv @@
// Top level of the 2D distance constraint projection block.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------
//   in      | in_valid / in_ready    | in_data  (two points, weights, rest)
//   out     | out_valid / out_ready  | out_data (new points, error, flag)
//
// One request per clock is sustained while out_ready stays high. From
// acceptance to its result a request passes one front register, the queue,
// 33 square root steps, 31 division steps, plus squaring, summing, error,
// product and output registers.
// Reset (rst, synchronous) clears all valid bits and queue pointers; data
// registers are not reset.
// A stalled output holds the back pipeline; the queue keeps absorbing
// requests from the front until it fills, then in_ready drops.
module distance_constraint_projection import dcp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic  f_valid;
  logic  f_ready;
  work_t f_work;
  logic  q_valid;
  logic  q_ready;
  work_t q_work;

  // classify: differences, magnitudes, signs, coincident points
  dcp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .work_valid (f_valid),
    .work_ready (f_ready),
    .work       (f_work)
  );

  // decouple front and back so each can stall on its own
  dcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_work  (f_work),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_work   (q_work)
  );

  // length, direction, error and saturated corrections
  dcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (q_valid),
    .work_ready (q_ready),
    .work       (q_work),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
